[rtl/assert_macros.svh]
// Assertion macros shared by the RTL of the line ending normalizer.
// Each macro expects signals named clk and arst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checks that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

[rtl/lenorm_pkg.sv]
// Package for the line ending normalizer: character codes, ending formats,
// register indexes and default widths. No dependencies.
`default_nettype none

package lenorm_pkg;

	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_NUL = 8'h00;

	typedef enum logic [1:0] {
		FMT_CR   = 2'd0,
		FMT_LF   = 2'd1,
		FMT_CRLF = 2'd2,
		FMT_LFCR = 2'd3
	} fmt_t;

	localparam int unsigned CFG_IDX_BITS = 2;
	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_TARGET_FORMAT = 2'd0,
		REG_OUT_CAPACITY  = 2'd1,
		REG_COUNT_ONLY    = 2'd2,
		REG_UNUSED        = 2'd3
	} reg_idx_t;

	localparam int unsigned CFG_DATA_BITS       = 32;
	localparam int unsigned LEN_OUT_BITS        = 32;
	localparam int unsigned LENGTH_BITS_DEFAULT = 32;

	// One input byte causes at most five output words.
	localparam int unsigned PLAN_DEPTH = 5;
	localparam int unsigned PLAN_BITS  = 3;

endpackage

`default_nettype wire

[rtl/line_ending_normalizer_core.sv]
// Line ending normalizer top level: input register, result sequencer and
// output register. Depends on lenorm_pkg and assert_macros.svh.
//
// The core takes a text stream one byte per word and rewrites every CR LF,
// LF CR, lone CR and lone LF into the ending chosen by target_format. A line
// break byte is held until the next byte shows whether it pairs. A NUL byte or
// a byte with in_last ends the stream with a NUL word carrying status and
// total_length; bytes after a NUL are dropped up to the next in_last. Each
// accepted byte sits in one input register while the sequencer sends its
// words, one per cycle unless out_ready holds them back, into a single
// output register. The next byte is taken only when the byte held causes no
// word or its last word has gone out; one byte causes at most five words.
// The output counter is LENGTH_BITS wide and saturates.
`default_nettype none

module line_ending_normalizer_core
	import lenorm_pkg::*;
#(
	parameter int unsigned LENGTH_BITS = LENGTH_BITS_DEFAULT
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_valid,
	output logic                          cfg_ready,
	input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  wire logic [CFG_DATA_BITS-1:0] cfg_data,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire logic [7:0]               in_byte,
	input  wire logic                     in_last,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output logic [7:0]                    out_byte,
	output logic                          written,
	output logic                          end_of_output,
	output logic                          status,
	output logic [LEN_OUT_BITS-1:0]       total_length
);

	localparam int unsigned CMP_BITS = (LENGTH_BITS > CFG_DATA_BITS) ? LENGTH_BITS : CFG_DATA_BITS;
	localparam int unsigned WIDE_BITS = (CMP_BITS > LEN_OUT_BITS) ? CMP_BITS : LEN_OUT_BITS;

	// Configuration registers.
	fmt_t                     fmt_q;
	logic [CFG_DATA_BITS-1:0] cap_q;
	logic                     cnt_only_q;

	// Stream state.
	logic                   pend_q;
	logic                   pend_cr_q;
	logic                   stop_q;
	logic                   ovf_q;
	logic [LENGTH_BITS-1:0] cnt_q;

	// Input register and result index.
	logic                 valid_s1;
	logic [7:0]           byte_s1;
	logic                 last_s1;
	logic [PLAN_BITS-1:0] idx_q;

	// Output register.
	logic                    out_valid_q;
	logic [7:0]              out_byte_q;
	logic                    written_q;
	logic                    end_q;
	logic                    status_q;
	logic [LEN_OUT_BITS-1:0] total_q;

	// Result plan for the byte in the input register.
	logic [7:0]           plan_byte [PLAN_DEPTH];
	logic [PLAN_DEPTH-1:0] plan_end;
	logic [PLAN_BITS-1:0] plan_n;
	logic                 nxt_pend;
	logic                 nxt_pend_cr;
	logic                 nxt_stop;

	logic       is_cr;
	logic       is_lf;
	logic       pair;
	logic [7:0] end0;
	logic [7:0] end1;
	logic       two_byte;

	logic                    emit;
	logic                    last_slot;
	logic                    done;
	logic                    fits;
	logic                    cnt_sat;
	logic                    wr;
	logic                    ovf_after;
	logic [LENGTH_BITS-1:0]  cnt_inc;
	logic [WIDE_BITS-1:0]    cnt_inc_wide;
	logic [LEN_OUT_BITS-1:0] len_sat;

	assign is_cr    = (byte_s1 == CH_CR);
	assign is_lf    = (byte_s1 == CH_LF);
	assign pair     = pend_q && ((pend_cr_q && is_lf) || (!pend_cr_q && is_cr));
	assign end0     = (fmt_q == FMT_CR || fmt_q == FMT_CRLF) ? CH_CR : CH_LF;
	assign end1     = (fmt_q == FMT_CRLF) ? CH_LF : CH_CR;
	assign two_byte = (fmt_q == FMT_CRLF || fmt_q == FMT_LFCR);

	// Lists the words this byte causes, in order; the stream state moves on
	// only when the last of them has gone out, or at once if there are none.
	always_comb begin
		for (int i = 0; i < PLAN_DEPTH; i++) begin
			plan_byte[i] = CH_NUL;
		end
		plan_end    = '0;
		plan_n      = '0;
		nxt_pend    = pend_q;
		nxt_pend_cr = pend_cr_q;
		nxt_stop    = stop_q;
		if (stop_q) begin
			nxt_stop = !last_s1;
		end else begin
			nxt_pend    = 1'b0;
			nxt_pend_cr = 1'b0;
			if (pend_q) begin
				plan_byte[plan_n] = end0;
				plan_n = plan_n + 1'b1;
				if (two_byte) begin
					plan_byte[plan_n] = end1;
					plan_n = plan_n + 1'b1;
				end
			end
			if (pair) begin
				if (last_s1) begin
					plan_end[plan_n] = 1'b1;
					plan_n = plan_n + 1'b1;
				end
			end else if (byte_s1 == CH_NUL) begin
				plan_end[plan_n] = 1'b1;
				plan_n = plan_n + 1'b1;
				nxt_stop = !last_s1;
			end else if (is_cr || is_lf) begin
				if (last_s1) begin
					plan_byte[plan_n] = end0;
					plan_n = plan_n + 1'b1;
					if (two_byte) begin
						plan_byte[plan_n] = end1;
						plan_n = plan_n + 1'b1;
					end
					plan_end[plan_n] = 1'b1;
					plan_n = plan_n + 1'b1;
				end else begin
					nxt_pend    = 1'b1;
					nxt_pend_cr = is_cr;
				end
			end else begin
				plan_byte[plan_n] = byte_s1;
				plan_n = plan_n + 1'b1;
				if (last_s1) begin
					plan_end[plan_n] = 1'b1;
					plan_n = plan_n + 1'b1;
				end
			end
		end
	end

	assign emit      = valid_s1 && (plan_n != '0) && (!out_valid_q || out_ready);
	assign last_slot = (idx_q == plan_n - 1'b1);
	assign done      = valid_s1 && ((plan_n == '0) || (emit && last_slot));
	assign in_ready  = !valid_s1 || done;
	assign cfg_ready = 1'b1;

	// Accounting for the word being sent.
	assign cnt_sat      = &cnt_q;
	assign fits         = CMP_BITS'(cnt_q) < CMP_BITS'(cap_q);
	assign wr           = !cnt_only_q && !ovf_q && fits && !cnt_sat;
	assign ovf_after    = ovf_q || (!cnt_only_q && !(fits && !cnt_sat));
	assign cnt_inc      = cnt_sat ? cnt_q : cnt_q + 1'b1;
	assign cnt_inc_wide = WIDE_BITS'(cnt_inc);
	assign len_sat      = (cnt_inc_wide > WIDE_BITS'({LEN_OUT_BITS{1'b1}})) ?
		{LEN_OUT_BITS{1'b1}} : cnt_inc_wide[LEN_OUT_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q      <= FMT_LF;
			cap_q      <= '0;
			cnt_only_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (reg_idx_t'(cfg_index))
				REG_TARGET_FORMAT: fmt_q      <= fmt_t'(cfg_data[1:0]);
				REG_OUT_CAPACITY:  cap_q      <= cfg_data;
				REG_COUNT_ONLY:    cnt_only_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			idx_q       <= '0;
			pend_q      <= 1'b0;
			pend_cr_q   <= 1'b0;
			stop_q      <= 1'b0;
			ovf_q       <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (done) begin
				idx_q     <= '0;
				pend_q    <= nxt_pend;
				pend_cr_q <= nxt_pend_cr;
				stop_q    <= nxt_stop;
			end else if (emit) begin
				idx_q <= idx_q + 1'b1;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
				if (plan_end[idx_q]) begin
					cnt_q <= '0;
					ovf_q <= 1'b0;
				end else begin
					cnt_q <= cnt_inc;
					ovf_q <= ovf_after;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_byte;
			last_s1 <= in_last;
		end
		if (emit) begin
			out_byte_q <= plan_byte[idx_q];
			written_q  <= wr;
			end_q      <= plan_end[idx_q];
			status_q   <= plan_end[idx_q] && ovf_after;
			total_q    <= plan_end[idx_q] ? len_sat : '0;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_byte      = out_byte_q;
	assign written       = written_q;
	assign end_of_output = end_q;
	assign status        = status_q;
	assign total_length  = total_q;

`include "assert_macros.svh"

	`ASSERT_CLK(a_idx_needs_item, (idx_q != '0) |-> valid_s1, "result index moved without an item")
	`ASSERT_CLK(a_end_clears_count, (emit && plan_end[idx_q]) |=> (cnt_q == '0 && !ovf_q), "count not cleared after end word")
	`ASSERT_NEVER(a_tail_fields, out_valid_q && !end_q && (status_q || total_q != '0), "status or length on a non-end word")
	`ASSERT_NEVER(a_count_only_write, out_valid_q && written_q && cnt_only_q, "word marked written in count-only mode")

endmodule

`default_nettype wire

[dv/tb_top.sv]
`timescale 1ns / 1ps
// Testbench for line_ending_normalizer_core: text streams with mixed line endings,
// random gaps on both channels, each output word checked against an in-bench rewrite.
// Depends on lenorm_pkg and the core RTL only.

module tb_top
	import lenorm_pkg::*;
;

	typedef struct packed {
		logic [7:0]              data;
		logic                    wr;
		logic                    eos;
		logic                    st;
		logic [LEN_OUT_BITS-1:0] len;
	} out_word_t;

	// Rewrites accepted bytes into the words the core should send, in order.
	class newline_rewriter;
		fmt_t        fmt = FMT_LF;
		logic [31:0] capacity = '0;
		bit          count_only = 1'b0;
		bit          held = 1'b0;
		bit          held_cr = 1'b0;
		bit          in_tail = 1'b0;
		bit          overflow = 1'b0;
		logic [31:0] out_count = '0;
		out_word_t   normalized_words[$];
		int unsigned mismatches = 0;

		function void set_reg(reg_idx_t idx, logic [31:0] data);
			case (idx)
				REG_TARGET_FORMAT: fmt = fmt_t'(data[1:0]);
				REG_OUT_CAPACITY: capacity = data;
				REG_COUNT_ONLY: count_only = data[0];
				default: ;
			endcase
		endfunction

		// Counts one output byte. It is stored only while it fits and nothing has
		// overflowed yet; a saturated counter never fits.
		function bit take_slot();
			bit fits;
			fits = 1'b0;
			if (!count_only && !overflow) begin
				if (out_count < capacity && out_count != '1)
					fits = 1'b1;
				else
					overflow = 1'b1;
			end
			if (out_count != '1)
				out_count++;
			return fits;
		endfunction

		function void put_byte(logic [7:0] b);
			out_word_t w;
			w = '0;
			w.data = b;
			w.wr = take_slot();
			normalized_words.push_back(w);
		endfunction

		function void put_ending();
			case (fmt)
				FMT_CR: put_byte(CH_CR);
				FMT_LF: put_byte(CH_LF);
				FMT_CRLF: begin
					put_byte(CH_CR);
					put_byte(CH_LF);
				end
				default: begin
					put_byte(CH_LF);
					put_byte(CH_CR);
				end
			endcase
		endfunction

		function void close_stream(bit last);
			out_word_t w;
			w = '0;
			w.data = CH_NUL;
			w.wr = take_slot();
			w.eos = 1'b1;
			w.st = overflow;
			w.len = out_count;
			normalized_words.push_back(w);
			held = 1'b0;
			held_cr = 1'b0;
			overflow = 1'b0;
			out_count = '0;
			in_tail = !last;
		endfunction

		// Returns 0 when the byte falls in the ignored tail after a NUL.
		function bit note_byte(logic [7:0] b, bit last);
			bit is_cr;
			bit is_lf;
			is_cr = (b == CH_CR);
			is_lf = (b == CH_LF);
			if (in_tail) begin
				if (last)
					in_tail = 1'b0;
				return 1'b0;
			end
			if (held) begin
				held = 1'b0;
				put_ending();
				if ((held_cr && is_lf) || (!held_cr && is_cr)) begin
					if (last)
						close_stream(1'b1);
					return 1'b1;
				end
			end
			if (b == CH_NUL) begin
				close_stream(last);
				return 1'b1;
			end
			if (is_cr || is_lf) begin
				if (last) begin
					put_ending();
				end else begin
					held = 1'b1;
					held_cr = is_cr;
				end
			end else begin
				put_byte(b);
			end
			if (last)
				close_stream(1'b1);
			return 1'b1;
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$error("%s: expected %0h, got %0h", name, want, got);
				mismatches++;
			end
		endfunction

		function void check_word(out_word_t got);
			out_word_t want;
			if (normalized_words.size() == 0) begin
				$error("output word %0h arrived with nothing expected", got.data);
				mismatches++;
				return;
			end
			want = normalized_words.pop_front();
			compare_field("out_byte", 32'(want.data), 32'(got.data));
			compare_field("written", 32'(want.wr), 32'(got.wr));
			compare_field("end_of_output", 32'(want.eos), 32'(got.eos));
			compare_field("status", 32'(want.st), 32'(got.st));
			compare_field("total_length", 32'(want.len), 32'(got.len));
		endfunction
	endclass

	logic                     clk;
	logic                     arst_n = 1'b0;
	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	reg_idx_t                 cfg_index = REG_TARGET_FORMAT;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;
	logic                     in_valid = 1'b0;
	logic                     in_ready;
	logic [7:0]               in_byte = '0;
	logic                     in_last = 1'b0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic [7:0]               out_byte;
	logic                     written;
	logic                     end_of_output;
	logic                     status;
	logic [LEN_OUT_BITS-1:0]  total_length;

	newline_rewriter rewriter = new;
	bit              tx_calm = 1'b0;
	bit              rx_calm = 1'b0;
	int unsigned     stall_left = 0;
	int unsigned     stream_bytes = 0;

	line_ending_normalizer_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.in_byte       (in_byte),
		.in_last       (in_last),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_byte      (out_byte),
		.written       (written),
		.end_of_output (end_of_output),
		.status        (status),
		.total_length  (total_length)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("simulation failed");
		$finish;
	end

	// Mostly short gaps, now and then a long one.
	function automatic int unsigned pick_gap();
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Output side: check every accepted word, then choose the next ready level.
	always @(posedge clk) begin
		out_word_t got;
		if (arst_n && out_valid && out_ready) begin
			got.data = out_byte;
			got.wr = written;
			got.eos = end_of_output;
			got.st = status;
			got.len = total_length;
			rewriter.check_word(got);
		end
		if ($urandom_range(0, 199) == 0)
			rx_calm = !rx_calm;
		if (stall_left != 0) begin
			out_ready <= 1'b0;
			stall_left--;
		end else if (!rx_calm && $urandom_range(0, 99) < 30) begin
			out_ready <= 1'b0;
			stall_left = pick_gap() - 1;
		end else begin
			out_ready <= 1'b1;
		end
	end

	task automatic push_byte(logic [7:0] b, bit last);
		int unsigned gap;
		in_valid <= 1'b1;
		in_byte <= b;
		in_last <= last;
		do @(posedge clk); while (!in_ready);
		if (rewriter.note_byte(b, last))
			stream_bytes++;
		gap = (!tx_calm && $urandom_range(0, 1)) ? pick_gap() : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stops sending, waits for every expected word, then idles on the clock so
	// that the core empties before anything else happens.
	task automatic settle();
		in_valid <= 1'b0;
		while (rewriter.normalized_words.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		rewriter.set_reg(idx, data);
	endtask

	// Upper data bits are random so that unused bits are seen to be dropped.
	task automatic program_regs(fmt_t f, logic [31:0] cap, bit cnt);
		logic [31:0] data;
		write_reg(REG_UNUSED, $urandom);
		data = $urandom;
		data[0] = cnt;
		write_reg(REG_COUNT_ONLY, data);
		write_reg(REG_OUT_CAPACITY, cap);
		data = $urandom;
		data[1:0] = f;
		write_reg(REG_TARGET_FORMAT, data);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_stream();
		int unsigned len;
		int unsigned r;
		logic [7:0]  b;
		len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
		tx_calm = ($urandom_range(0, 3) == 0);
		for (int unsigned i = 0; i < len; i++) begin
			r = $urandom_range(0, 99);
			if (r < 50)
				b = 8'($urandom_range(8'h20, 8'h7E));
			else if (r < 67)
				b = CH_CR;
			else if (r < 84)
				b = CH_LF;
			else if (r < 88)
				b = CH_NUL;
			else
				b = 8'($urandom_range(0, 255));
			if ($urandom_range(0, 29) == 0)
				settle();
			push_byte(b, i == len - 1);
		end
	endtask

	task automatic run_phase(fmt_t f, logic [31:0] cap, bit cnt, int unsigned n);
		settle();
		program_regs(f, cap, cnt);
		stream_bytes = 0;
		while (stream_bytes < n)
			random_stream();
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Settings after reset: LF endings and no room, so every byte overflows.
		push_byte(8'h78, 1'b0);
		push_byte(CH_CR, 1'b1);

		settle();
		program_regs(FMT_CRLF, 32'd10, 1'b0);
		// Pairs in both orders, a doubled CR, and an overflow on the end word.
		push_byte(8'h61, 1'b0);
		push_byte(CH_CR, 1'b0);
		push_byte(CH_LF, 1'b0);
		push_byte(CH_LF, 1'b0);
		push_byte(CH_CR, 1'b0);
		push_byte(CH_CR, 1'b0);
		push_byte(CH_CR, 1'b0);
		push_byte(CH_LF, 1'b0);
		push_byte(8'hFF, 1'b1);
		// A held LF across a full pause, flushed by a NUL, then an ignored tail.
		push_byte(CH_LF, 1'b0);
		settle();
		push_byte(CH_NUL, 1'b0);
		push_byte(8'h41, 1'b0);
		push_byte(CH_CR, 1'b0);
		push_byte(8'hFF, 1'b1);
		// A lone NUL stream and line breaks on the last byte.
		push_byte(CH_NUL, 1'b1);
		push_byte(CH_CR, 1'b1);
		push_byte(CH_LF, 1'b0);
		push_byte(CH_LF, 1'b1);
		push_byte(CH_CR, 1'b0);
		push_byte(CH_LF, 1'b1);

		run_phase(FMT_CR, 32'hFFFF_FFFF, 1'b0, 16);
		run_phase(FMT_LF, 32'd0, 1'b0, 16);
		run_phase(FMT_LFCR, 32'd0, 1'b1, 16);
		run_phase(FMT_CRLF, $urandom_range(1, 16), 1'b0, 16);
		run_phase(FMT_LFCR, $urandom_range(4, 24), 1'b0, 16);
		run_phase(FMT_CR, $urandom, 1'b1, 16);
		run_phase(fmt_t'($urandom_range(0, 3)), $urandom_range(0, 40), 1'b0, 16);
		run_phase(FMT_LF, 32'hFFFF_FFFF, 1'b0, 16);

		settle();
		if (rewriter.mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

[line_ending_normalizer_core.f]
+incdir+rtl
rtl/lenorm_pkg.sv
rtl/line_ending_normalizer_core.sv
dv/tb_top.sv
